FILE: rtl/core/botl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the blocked offset-table lookup core.
// Used by botl_ctrl, botl_datapath and blocked_offset_table_lookup_core.

package botl_pkg;

  localparam int DOC_W         = 12;
  localparam int ADDR_W        = 48;
  localparam int SIZE_W        = 16;
  localparam int SEG_FIELD_W   = 2;
  localparam int SEGS_IN_USE_W = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int DATA_BASES    = 4;

  // Item action codes.
  localparam logic [1:0] ACT_WRITE_BASE = 2'd0;
  localparam logic [1:0] ACT_WRITE_SIZE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP     = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE_0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE_1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE_2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE_3     = 3'd4;

  typedef struct packed {
    logic [1:0]             action;
    logic [SEG_FIELD_W-1:0] segment;
    logic [DOC_W-1:0]       doc_id;
    logic [ADDR_W-1:0]      value;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] entry_size;
    logic              status;
  } result_t;

  typedef struct packed {
    logic load;
    logic div;
    logic slot;
    logic blk;
    logic mem_write;
    logic base_rd;
    logic scan;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic lookup_ok;
    logic scan_last;
  } dp_status_t;

endpackage

FILE: rtl/core/blocked_offset_table_lookup_core.sv
`timescale 1ns / 1ps
// Blocked offset-table lookup core: locates variable-length records from a
// per-block base offset plus the sizes of the earlier slots in that block.
//
// Usage: an item beat (item) is accepted on a clock edge with start high and
// busy low. Its action writes a block base, writes a slot size, or looks up a
// record. Every item yields exactly one result beat: result is valid for the
// single cycle in which done is high; the receiver cannot hold it off.
// Configuration registers are written through cfg_we / cfg_index / cfg_data
// only while the core is idle, a rule for the user that the core does not
// enforce; writes take effect on the next edge. Writes and rejected lookups
// step through S_DIV, S_SLOT, S_BLK and S_WRITE back to idle, done being high
// in the first idle cycle. A lookup steps through S_BASE, S_SCAN over slots 0
// to slot (slot = doc_id mod BLOCK_SIZE), S_DRAIN and S_ADD after decode; the
// single-port slot size store is read and summed one size per cycle.
// Reset clears the sequencer, the strobe and the configuration registers.
// The base and size stores are not cleared; entries must be written before
// they are looked up.
// Depends on botl_pkg, botl_ctrl and botl_datapath.

module blocked_offset_table_lookup_core #(
  parameter int BLOCK_SIZE         = 16,
  parameter int BLOCKS_PER_SEGMENT = 256,
  parameter int SEGMENTS           = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  botl_pkg::item_t                item,
  input  logic                           cfg_we,
  input  logic [botl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [botl_pkg::ADDR_W-1:0]    cfg_data,
  output botl_pkg::result_t              result,
  output logic                           done
);
  import botl_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  botl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  botl_datapath #(
    .BLOCK_SIZE         (BLOCK_SIZE),
    .BLOCKS_PER_SEGMENT (BLOCKS_PER_SEGMENT),
    .SEGMENTS           (SEGMENTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .result    (result),
    .done      (done)
  );

endmodule

FILE: rtl/core/botl_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the lookup core: steps one item through decode, store access
// and result. Depends on botl_pkg for the command and status structs.

module botl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  botl_pkg::dp_status_t status,
  output botl_pkg::ctrl_cmd_t  cmd
);
  import botl_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIV   = 9'b000000010,
    S_SLOT  = 9'b000000100,
    S_BLK   = 9'b000001000,
    S_WRITE = 9'b000010000,
    S_BASE  = 9'b000100000,
    S_SCAN  = 9'b001000000,
    S_DRAIN = 9'b010000000,
    S_ADD   = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div    = 1'b1;
        state_next = S_SLOT;
      end
      S_SLOT: begin
        cmd.slot   = 1'b1;
        state_next = S_BLK;
      end
      S_BLK: begin
        cmd.blk = 1'b1;
        if (status.is_lookup && status.lookup_ok) begin
          state_next = S_BASE;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.mem_write = 1'b1;
        cmd.emit      = 1'b1;
        state_next    = S_IDLE;
      end
      S_BASE: begin
        cmd.base_rd = 1'b1;
        state_next  = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  // An accepted item always occupies the sequencer in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("sequencer did not leave idle after accepting an item");

endmodule

FILE: rtl/core/botl_datapath.sv
`timescale 1ns / 1ps
// Datapath of the lookup core: configuration registers, doc_id split, base and
// slot-size stores, prefix-sum accumulator and result register. Uses botl_pkg.

module botl_datapath #(
  parameter int BLOCK_SIZE         = 16,
  parameter int BLOCKS_PER_SEGMENT = 256,
  parameter int SEGMENTS           = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  botl_pkg::item_t                       item,
  input  logic                                  cfg_we,
  input  logic [botl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [botl_pkg::ADDR_W-1:0]           cfg_data,
  input  botl_pkg::ctrl_cmd_t                   cmd,
  output botl_pkg::dp_status_t                  status,
  output botl_pkg::result_t                     result,
  output logic                                  done
);
  import botl_pkg::*;

  localparam int SLOT_W   = $clog2(BLOCK_SIZE);
  localparam int BLK_L    = $clog2(BLOCKS_PER_SEGMENT);
  localparam int BLK_W    = (BLK_L > 0) ? BLK_L : 1;
  localparam int BPS_W    = $clog2(BLOCKS_PER_SEGMENT + 1);
  localparam int MUL_W    = DOC_W + 1;
  // Division by a constant as multiply by a rounded-up reciprocal; exact for
  // every DOC_W-bit numerator.
  localparam int BLK_SHIFT = DOC_W + SLOT_W;
  localparam int BLK_MUL   = ((1 << BLK_SHIFT) + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int MOD_SHIFT = DOC_W + BLK_L;
  localparam int MOD_MUL   = ((1 << MOD_SHIFT) + BLOCKS_PER_SEGMENT - 1) / BLOCKS_PER_SEGMENT;
  localparam int BASE_DEPTH = SEGMENTS << BLK_W;
  localparam int BASE_A_W   = $clog2(BASE_DEPTH);
  localparam int SIZE_DEPTH = SEGMENTS << (BLK_W + SLOT_W);
  localparam int SIZE_A_W   = $clog2(SIZE_DEPTH);

  // Configuration registers.
  logic [SEGS_IN_USE_W-1:0] seg_in_use;
  logic [ADDR_W-1:0]        data_base [DATA_BASES];

  // Item and decode registers.
  item_t             item_r;
  logic [DOC_W-1:0]  q1;
  logic [DOC_W-1:0]  q2;
  logic [SLOT_W-1:0] slot_r;
  logic [BLK_W-1:0]  blk_r;

  // Scan registers.
  logic [SLOT_W-1:0] idx;
  logic              pend;
  logic              pend_last;
  logic [SIZE_W-1:0] rd_data;
  logic [ADDR_W-1:0] base_q;
  logic [ADDR_W-1:0] acc;
  logic [SIZE_W-1:0] size_r;
  result_t           result_r;

  logic [ADDR_W-1:0] base_mem [BASE_DEPTH];
  logic [SIZE_W-1:0] size_mem [SIZE_DEPTH];

  logic [DOC_W+MUL_W-1:0]  prod1;
  logic [DOC_W+MUL_W-1:0]  prod2;
  logic [DOC_W+SLOT_W:0]   back1;
  logic [DOC_W+BPS_W-1:0]  back2;
  logic [DOC_W+BPS_W-1:0]  wide_blk;
  logic [BASE_A_W-1:0]     base_addr;
  logic [SIZE_A_W-1:0]     size_wr_addr;
  logic [SIZE_A_W-1:0]     size_rd_addr;
  logic                    seg_exists;
  logic                    seg_active;
  logic                    lookup_hit;

  assign prod1    = item_r.doc_id * MUL_W'(BLK_MUL);
  assign prod2    = q1 * MUL_W'(MOD_MUL);
  assign back1    = q1 * (SLOT_W + 1)'(BLOCK_SIZE);
  assign back2    = q2 * BPS_W'(BLOCKS_PER_SEGMENT);
  assign wide_blk = (DOC_W + BPS_W)'(q1) - back2;

  assign base_addr    = BASE_A_W'({item_r.segment, blk_r});
  assign size_wr_addr = SIZE_A_W'({item_r.segment, blk_r, slot_r});
  assign size_rd_addr = SIZE_A_W'({item_r.segment, blk_r, idx});

  assign seg_exists = ({1'b0, item_r.segment} < SEGS_IN_USE_W'(SEGMENTS));
  assign seg_active = seg_exists && ({1'b0, item_r.segment} < seg_in_use);
  assign lookup_hit = status.is_lookup && status.lookup_ok;

  assign status.is_lookup = (item_r.action == ACT_LOOKUP);
  assign status.lookup_ok = seg_active;
  assign status.scan_last = (idx == slot_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_in_use <= '0;
      for (int i = 0; i < DATA_BASES; i++) begin
        data_base[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEGMENTS_IN_USE: seg_in_use   <= cfg_data[SEGS_IN_USE_W-1:0];
        CFG_DATA_BASE_0:     data_base[0] <= cfg_data;
        CFG_DATA_BASE_1:     data_base[1] <= cfg_data;
        CFG_DATA_BASE_2:     data_base[2] <= cfg_data;
        CFG_DATA_BASE_3:     data_base[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      pend <= cmd.scan;
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= item;
      idx    <= '0;
    end
    if (cmd.div) begin
      q1 <= DOC_W'(prod1 >> BLK_SHIFT);
    end
    if (cmd.slot) begin
      slot_r <= SLOT_W'(item_r.doc_id - DOC_W'(back1));
      q2     <= DOC_W'(prod2 >> MOD_SHIFT);
    end
    if (cmd.blk) begin
      blk_r <= BLK_W'(wide_blk);
    end
    if (cmd.scan) begin
      pend_last <= (idx == slot_r);
      idx       <= idx + 1'b1;
      // The block base read in S_BASE is now in base_q; it seeds the sum.
      if (idx == '0) begin
        acc <= base_q;
      end
    end
    if (pend) begin
      if (pend_last) begin
        size_r <= rd_data;
      end else begin
        acc <= acc + ADDR_W'(rd_data);
      end
    end
    if (cmd.emit) begin
      result_r.address    <= lookup_hit ? acc + data_base[item_r.segment] : '0;
      result_r.entry_size <= lookup_hit ? size_r : '0;
      result_r.status     <= status.is_lookup && !status.lookup_ok;
    end
  end

  // Block base store.
  always_ff @(posedge clk) begin
    if (cmd.mem_write && seg_exists && (item_r.action == ACT_WRITE_BASE)) begin
      base_mem[base_addr] <= item_r.value;
    end
    if (cmd.base_rd) begin
      base_q <= base_mem[base_addr];
    end
  end

  // Slot size store.
  always_ff @(posedge clk) begin
    if (cmd.mem_write && seg_exists && (item_r.action == ACT_WRITE_SIZE)) begin
      size_mem[size_wr_addr] <= item_r.value[SIZE_W-1:0];
    end
    if (cmd.scan) begin
      rd_data <= size_mem[size_rd_addr];
    end
  end

  assign result = result_r;

  a_emit_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !pend)
    else $error("result emitted while a slot size read was still in flight");

  a_scan_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (pend && !pend_last) |=> pend)
    else $error("slot size reads stopped before the selected slot");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |-> (result.address == '0 && result.entry_size == '0))
    else $error("error result carries a nonzero address or size");

endmodule

FILE: bench/blocked_offset_table_lookup_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for blocked_offset_table_lookup_core: random and directed
// beats go through the start/busy port, and results are checked against a predictor.
// Depends on botl_pkg and the core RTL only.

module blocked_offset_table_lookup_core_tb;
  import botl_pkg::*;

  localparam int BLOCK_SIZE         = 16;
  localparam int BLOCKS_PER_SEGMENT = 256;
  localparam int SEGMENTS           = 4;
  localparam int NUM_BLOCKS         = SEGMENTS * BLOCKS_PER_SEGMENT;
  localparam int NUM_SLOTS          = NUM_BLOCKS * BLOCK_SIZE;
  localparam int CYCLE_LIMIT        = 600000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  class lookup_scoreboard;
    logic [ADDR_W-1:0] base_store[];
    logic [SIZE_W-1:0] size_store[];
    logic [ADDR_W-1:0] data_origin[];
    logic [SEGS_IN_USE_W-1:0] live_segments;
    result_t expected_q[$];
    int mismatches;

    function new();
      base_store = new[NUM_BLOCKS];
      size_store = new[NUM_SLOTS];
      data_origin = new[DATA_BASES];
      foreach (data_origin[i]) data_origin[i] = '0;
      live_segments = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] d);
      case (idx)
        CFG_SEGMENTS_IN_USE: live_segments = d[SEGS_IN_USE_W-1:0];
        CFG_DATA_BASE_0: data_origin[0] = d;
        CFG_DATA_BASE_1: data_origin[1] = d;
        CFG_DATA_BASE_2: data_origin[2] = d;
        CFG_DATA_BASE_3: data_origin[3] = d;
        default: ;
      endcase
    endfunction

    // Updates the stores and queues the result this beat must produce.
    function void note_item(item_t it);
      result_t r;
      int blk;
      int slot;
      logic [ADDR_W-1:0] pos;
      r = '0;
      blk = int'(it.segment) * BLOCKS_PER_SEGMENT +
            (int'(it.doc_id) / BLOCK_SIZE) % BLOCKS_PER_SEGMENT;
      slot = int'(it.doc_id) % BLOCK_SIZE;
      case (it.action)
        ACT_WRITE_BASE: base_store[blk] = it.value;
        ACT_WRITE_SIZE: size_store[blk * BLOCK_SIZE + slot] = it.value[SIZE_W-1:0];
        ACT_LOOKUP: begin
          if (int'(it.segment) >= int'(live_segments)) begin
            r.status = 1'b1;
          end else begin
            pos = base_store[blk];
            for (int i = 0; i < slot; i++) pos = pos + size_store[blk * BLOCK_SIZE + i];
            r.entry_size = size_store[blk * BLOCK_SIZE + slot];
            r.address = data_origin[it.segment] + pos;
          end
        end
        default: ;
      endcase
      expected_q = {expected_q, r};
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: address %h size %h status %b",
                   got.address, got.entry_size, got.status);
        return;
      end
      want = expected_q.pop_front();
      if (got.address !== want.address || got.entry_size !== want.entry_size ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected address %h size %h status %b, got %h %h %b",
                   want.address, want.entry_size, want.status,
                   got.address, got.entry_size, got.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t item = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0] cfg_data = '0;
  result_t result;
  logic done;

  lookup_scoreboard sb;
  bit base_written[NUM_BLOCKS];
  bit size_written[NUM_SLOTS];
  bit burst = 1'b0;
  int items_sent = 0;
  int cycles = 0;

  blocked_offset_table_lookup_core #(
    .BLOCK_SIZE(BLOCK_SIZE),
    .BLOCKS_PER_SEGMENT(BLOCKS_PER_SEGMENT),
    .SEGMENTS(SEGMENTS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result(result),
    .done(done)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] rand_value();
    logic [63:0] w;
    int pick;
    pick = $urandom_range(0, 7);
    w = {$urandom, $urandom};
    if (pick == 0) return '0;
    if (pick == 1) return ADDR_MAX;
    return w[ADDR_W-1:0];
  endfunction

  function automatic item_t make_item(logic [1:0] act, logic [1:0] seg,
                                      logic [DOC_W-1:0] doc, logic [ADDR_W-1:0] v);
    item_t it;
    it.action = act;
    it.segment = seg;
    it.doc_id = doc;
    it.value = v;
    return it;
  endfunction

  // Most lookups land in a few hot blocks so that stored entries get reused.
  function automatic logic [DOC_W-1:0] pick_doc();
    int blk;
    int hot_pick;
    hot_pick = $urandom_range(0, 5);
    if ($urandom_range(0, 9) < 7)
      blk = (hot_pick < 3) ? hot_pick : (hot_pick == 3 ? 127 : (hot_pick == 4 ? 128 : 255));
    else
      blk = $urandom_range(0, BLOCKS_PER_SEGMENT - 1);
    return DOC_W'(blk * BLOCK_SIZE + $urandom_range(0, BLOCK_SIZE - 1));
  endfunction

  task automatic send_item(item_t it);
    int gap;
    int blk;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    items_sent++;
    blk = int'(it.segment) * BLOCKS_PER_SEGMENT +
          (int'(it.doc_id) / BLOCK_SIZE) % BLOCKS_PER_SEGMENT;
    if (it.action == ACT_WRITE_BASE) base_written[blk] = 1'b1;
    if (it.action == ACT_WRITE_SIZE)
      size_written[blk * BLOCK_SIZE + int'(it.doc_id) % BLOCK_SIZE] = 1'b1;
  endtask

  // Holds off the sender until every outstanding result beat has arrived.
  task automatic drain();
    start <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic apply_setting(int live, logic [ADDR_W-1:0] b0, logic [ADDR_W-1:0] b1,
                               logic [ADDR_W-1:0] b2, logic [ADDR_W-1:0] b3);
    drain();
    cfg_write(CFG_SEGMENTS_IN_USE, ADDR_W'(live));
    cfg_write(CFG_DATA_BASE_0, b0);
    cfg_write(CFG_DATA_BASE_1, b1);
    cfg_write(CFG_DATA_BASE_2, b2);
    cfg_write(CFG_DATA_BASE_3, b3);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // A lookup in a live segment first loads whatever base and sizes it would
  // read that were never written, so no stale entry is ever looked up.
  task automatic lookup_record(logic [1:0] seg, logic [DOC_W-1:0] doc);
    int blk;
    int slot;
    int first_doc;
    blk = int'(seg) * BLOCKS_PER_SEGMENT + (int'(doc) / BLOCK_SIZE) % BLOCKS_PER_SEGMENT;
    slot = int'(doc) % BLOCK_SIZE;
    first_doc = int'(doc) - slot;
    if (int'(seg) < int'(sb.live_segments)) begin
      if (!base_written[blk])
        send_item(make_item(ACT_WRITE_BASE, seg, doc, rand_value()));
      for (int i = 0; i <= slot; i++) begin
        if (!size_written[blk * BLOCK_SIZE + i])
          send_item(make_item(ACT_WRITE_SIZE, seg, DOC_W'(first_doc + i), rand_value()));
      end
    end
    send_item(make_item(ACT_LOOKUP, seg, doc, rand_value()));
  endtask

  task automatic random_items(int count);
    int stop_at;
    int sel;
    logic [1:0] seg;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      sel = $urandom_range(0, 99);
      seg = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 39) == 0) burst = !burst;
      if ($urandom_range(0, 199) == 0) drain();
      if (sel < 60)
        lookup_record(seg, pick_doc());
      else if (sel < 78)
        send_item(make_item(ACT_WRITE_SIZE, seg, pick_doc(), rand_value()));
      else if (sel < 94)
        send_item(make_item(ACT_WRITE_BASE, seg, pick_doc(), rand_value()));
      else
        send_item(make_item(ACT_UNUSED, seg, DOC_W'($urandom), rand_value()));
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // No segment is live after reset, so lookups are rejected without reads.
    send_item(make_item(ACT_LOOKUP, 2'd0, '0, '0));
    send_item(make_item(ACT_LOOKUP, 2'd3, '1, ADDR_MAX));
    send_item(make_item(ACT_UNUSED, 2'd0, '0, '0));
    send_item(make_item(ACT_UNUSED, 2'd3, '1, ADDR_MAX));

    apply_setting(4, ADDR_MAX, '0, 48'h0000_8000_0000, ADDR_MAX);
    // Largest base, data base and first two sizes make the address wrap at 48 bits.
    send_item(make_item(ACT_WRITE_BASE, 2'd0, 12'h000, ADDR_MAX));
    send_item(make_item(ACT_WRITE_SIZE, 2'd0, 12'h000, 48'h0000_0000_FFFF));
    send_item(make_item(ACT_WRITE_SIZE, 2'd0, 12'h001, ADDR_MAX));
    send_item(make_item(ACT_WRITE_SIZE, 2'd0, 12'h002, 48'hABCD_0000_0000));
    send_item(make_item(ACT_LOOKUP, 2'd0, 12'h000, '0));
    send_item(make_item(ACT_LOOKUP, 2'd0, 12'h001, '0));
    send_item(make_item(ACT_LOOKUP, 2'd0, 12'h002, ADDR_MAX));
    send_item(make_item(ACT_WRITE_BASE, 2'd3, 12'hFF0, '0));
    send_item(make_item(ACT_WRITE_SIZE, 2'd3, 12'hFF0, '0));
    send_item(make_item(ACT_LOOKUP, 2'd3, 12'hFF0, '0));
    lookup_record(2'd2, 12'h805);

    apply_setting(4, rand_value(), rand_value(), rand_value(), rand_value());
    random_items(200);
    apply_setting(2, '0, ADDR_MAX, rand_value(), rand_value());
    random_items(150);
    apply_setting(0, rand_value(), rand_value(), rand_value(), rand_value());
    random_items(40);
    apply_setting(1, ADDR_MAX, rand_value(), rand_value(), rand_value());
    random_items(120);
    apply_setting(3, rand_value(), rand_value(), rand_value(), rand_value());
    random_items(150);
    apply_setting(4, '0, ADDR_MAX, ADDR_MAX, '0);
    random_items(200);

    start <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/botl_pkg.sv
rtl/core/botl_ctrl.sv
rtl/core/botl_datapath.sv
rtl/core/blocked_offset_table_lookup_core.sv
bench/blocked_offset_table_lookup_core_tb.sv
